[hdl/smah_pkg.sv]
// Shared types and constants for the supply monitor with averaging and hysteresis.
// No dependencies.
`default_nettype none

package smah_pkg;

  localparam int WINDOW_LENGTH_DEF = 8;
  localparam int NUM_CH = 4;
  localparam int MV_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS = 4;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] CH_LINE = 2'd0;
  localparam logic [1:0] CH_RESERVE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_ABSENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PRESENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVE_LOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVE_OK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ISO_TRIP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ISO_CLEAR = 3'd5;

  localparam logic [MV_W-1:0] RST_LINE_ABSENT = 16'd3000;
  localparam logic [MV_W-1:0] RST_LINE_PRESENT = 16'd4000;
  localparam logic [MV_W-1:0] RST_RESERVE_LOW = 16'd3700;
  localparam logic [MV_W-1:0] RST_RESERVE_OK = 16'd4000;
  localparam logic [MV_W-1:0] RST_ISO_TRIP = 16'd3000;
  localparam logic [MV_W-1:0] RST_ISO_CLEAR = 16'd4500;

  typedef struct packed {
    logic            opcode;
    logic [1:0]      channel;
    logic [MV_W-1:0] sample_mv;
    logic            mode_normal;
  } in_item_t;

  typedef struct packed {
    logic [MV_W-1:0] average_mv;
    logic            on_reserve;
    logic            reserve_is_low;
    logic            isolation_active;
    logic [3:0]      valid_mask;
  } out_item_t;

  typedef struct packed {
    logic            is_tick;
    logic [1:0]      channel;
    logic [MV_W-1:0] sample_mv;
    logic            mode_normal;
  } q_item_t;

  typedef struct packed {
    logic [MV_W-1:0] line_absent_mv;
    logic [MV_W-1:0] line_present_mv;
    logic [MV_W-1:0] reserve_low_mv;
    logic [MV_W-1:0] reserve_ok_mv;
    logic [MV_W-1:0] isolation_trip_mv;
    logic [MV_W-1:0] isolation_clear_mv;
  } cfg_t;

  typedef struct packed {
    logic            done;
    logic [MV_W-1:0] quotient;
  } div_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_EVAL,
    ST_DONE
  } bk_state_t;

endpackage

`default_nettype wire

[hdl/smah_divider.sv]
// Iterative restoring divider, DIV_STEPS quotient bits per cycle.
// Depends on smah_pkg.
`default_nettype none

module smah_divider #(
  parameter int DVD_W = 19,
  parameter int DVS_W = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [DVD_W-1:0]       dividend,
  input  wire logic [DVS_W-1:0]       divisor,
  output smah_pkg::div_res_t          res
);

  localparam int STEPS = smah_pkg::DIV_STEPS;
  localparam int ITER = (DVD_W + STEPS - 1) / STEPS;
  localparam int DW = ITER * STEPS;
  localparam int CW = $clog2(ITER + 1);

  logic [DW-1:0]    q_r, q_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;

  always_comb begin
    logic [DVS_W:0] sh;
    rem_nxt = rem_r;
    q_nxt = q_r;
    for (int i = 0; i < STEPS; i++) begin
      sh = {rem_nxt, q_nxt[DW-1]};
      q_nxt = {q_nxt[DW-2:0], 1'b0};
      if (sh >= {1'b0, dvs_r}) begin
        rem_nxt = DVS_W'(sh - {1'b0, dvs_r});
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = sh[DVS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= CW'(ITER);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= DW'(dividend);
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign res.done = done_r;
  assign res.quotient = q_r[smah_pkg::MV_W-1:0];

endmodule

`default_nettype wire

[hdl/smah_front.sv]
// Front end: accepts items, classifies sample/tick and queues them for the back end.
// Depends on smah_pkg.
`default_nettype none

module smah_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire smah_pkg::in_item_t  in_data,
  output logic                     q_valid,
  output smah_pkg::q_item_t        q_item,
  input  wire logic                q_pop
);

  localparam int QD = smah_pkg::QUEUE_DEPTH;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW = $clog2(QD + 1);

  smah_pkg::q_item_t q_mem_r [QD];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          push;
  logic          pop;

  assign in_stall = (cnt_r == CW'(QD));
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != '0);
  assign pop = q_pop && q_valid;
  assign q_item = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QD - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QD - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r].is_tick <= (in_data.opcode == smah_pkg::OP_TICK);
      q_mem_r[wr_ptr_r].channel <= in_data.channel;
      q_mem_r[wr_ptr_r].sample_mv <= in_data.sample_mv;
      q_mem_r[wr_ptr_r].mode_normal <= in_data.mode_normal;
    end
  end

endmodule

`default_nettype wire

[hdl/smah_back.sv]
// Back end: sample windows, running sums, means, hysteresis flags, result register.
// Depends on smah_pkg and smah_divider.
`default_nettype none

module smah_back #(
  parameter int WINDOW_LENGTH = smah_pkg::WINDOW_LENGTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire smah_pkg::cfg_t      cfg,
  input  wire logic                q_valid,
  input  wire smah_pkg::q_item_t   q_item,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output smah_pkg::out_item_t      out_data
);

  localparam int NCH = smah_pkg::NUM_CH;
  localparam int MV_W = smah_pkg::MV_W;
  localparam int PW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int FW = $clog2(WINDOW_LENGTH + 1);
  localparam int SUM_W = MV_W + $clog2(WINDOW_LENGTH);
  localparam int MEM_D = NCH * WINDOW_LENGTH;
  localparam int AW = $clog2(MEM_D);
  localparam logic [AW-1:0] W_A = AW'(WINDOW_LENGTH);
  localparam logic [FW-1:0] FILL_FULL = FW'(WINDOW_LENGTH);
  localparam logic [PW-1:0] POS_LAST = PW'(WINDOW_LENGTH - 1);

  smah_pkg::bk_state_t st_r, st_nxt;
  smah_pkg::q_item_t   item_r;
  smah_pkg::out_item_t out_data_r;
  smah_pkg::div_res_t  div_res;

  logic [MV_W-1:0]  win_mem [MEM_D];
  logic [MV_W-1:0]  rd_r;
  logic [AW-1:0]    addr_r;
  logic [AW-1:0]    rd_addr;
  logic [FW-1:0]    fill_r [NCH];
  logic [PW-1:0]    pos_r [NCH];
  logic [SUM_W-1:0] sum_r [NCH];
  logic [MV_W-1:0]  mean_r [NCH];
  logic [MV_W-1:0]  res_avg_r;
  logic             rp_r, rl_r, iso_r, seen_r;
  logic             out_valid_r;

  logic             out_free;
  logic             pop, div_start, div_take, eval_en, load_out;
  logic             full;
  logic [SUM_W-1:0] sum_nxt;
  logic [FW-1:0]    fill_nxt;
  logic [PW-1:0]    pos_nxt;
  logic             rp_nxt, rl_nxt, iso_nxt, seen_nxt;
  logic [3:0]       mask;

  assign out_free = !out_valid_r || !out_stall;
  assign rd_addr = AW'(q_item.channel) * W_A + AW'(pos_r[q_item.channel]);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      smah_pkg::ST_IDLE: begin
        if (q_valid) begin
          st_nxt = q_item.is_tick ? smah_pkg::ST_EVAL : smah_pkg::ST_SUM;
        end
      end
      smah_pkg::ST_SUM: st_nxt = smah_pkg::ST_DIV;
      smah_pkg::ST_DIV: begin
        if (div_res.done) begin
          st_nxt = smah_pkg::ST_DONE;
        end
      end
      smah_pkg::ST_EVAL: st_nxt = smah_pkg::ST_DONE;
      smah_pkg::ST_DONE: begin
        if (out_free) begin
          st_nxt = smah_pkg::ST_IDLE;
        end
      end
      default: st_nxt = smah_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    div_start = 1'b0;
    div_take = 1'b0;
    eval_en = 1'b0;
    load_out = 1'b0;
    unique case (st_r)
      smah_pkg::ST_IDLE: pop = q_valid;
      smah_pkg::ST_SUM:  div_start = 1'b1;
      smah_pkg::ST_DIV:  div_take = div_res.done;
      smah_pkg::ST_EVAL: eval_en = 1'b1;
      smah_pkg::ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  assign q_pop = pop;

  // window update for the item in hand
  assign full = (fill_r[item_r.channel] == FILL_FULL);
  assign sum_nxt = sum_r[item_r.channel] - (full ? SUM_W'(rd_r) : '0)
                   + SUM_W'(item_r.sample_mv);
  assign fill_nxt = full ? fill_r[item_r.channel] : fill_r[item_r.channel] + 1'b1;
  assign pos_nxt = (pos_r[item_r.channel] == POS_LAST) ? '0
                   : pos_r[item_r.channel] + 1'b1;

  // hysteresis rules
  always_comb begin
    rp_nxt = rp_r;
    seen_nxt = seen_r;
    iso_nxt = iso_r;
    rl_nxt = rl_r;
    if (fill_r[smah_pkg::CH_LINE] != '0) begin
      if (!rp_r && mean_r[smah_pkg::CH_LINE] < cfg.line_absent_mv) begin
        rp_nxt = 1'b1;
      end else if (rp_r && mean_r[smah_pkg::CH_LINE] > cfg.line_present_mv) begin
        rp_nxt = 1'b0;
      end
      if (mean_r[smah_pkg::CH_LINE] > cfg.line_present_mv) begin
        seen_nxt = 1'b1;
      end
      if (seen_nxt && item_r.mode_normal) begin
        if (!iso_r && mean_r[smah_pkg::CH_LINE] < cfg.isolation_trip_mv) begin
          iso_nxt = 1'b1;
        end else if (iso_r && mean_r[smah_pkg::CH_LINE] > cfg.isolation_clear_mv) begin
          iso_nxt = 1'b0;
        end
      end
    end
    if (fill_r[smah_pkg::CH_RESERVE] != '0) begin
      if (!rl_r && mean_r[smah_pkg::CH_RESERVE] < cfg.reserve_low_mv) begin
        rl_nxt = 1'b1;
      end else if (rl_r && mean_r[smah_pkg::CH_RESERVE] > cfg.reserve_ok_mv) begin
        rl_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      mask[c] = (fill_r[c] != '0);
    end
  end

  smah_divider #(
    .DVD_W(SUM_W),
    .DVS_W(FW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (fill_nxt),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= smah_pkg::ST_IDLE;
      for (int c = 0; c < NCH; c++) begin
        fill_r[c] <= '0;
        pos_r[c] <= '0;
        sum_r[c] <= '0;
        mean_r[c] <= '0;
      end
      rp_r <= 1'b0;
      rl_r <= 1'b0;
      iso_r <= 1'b0;
      seen_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (div_start) begin
        fill_r[item_r.channel] <= fill_nxt;
        pos_r[item_r.channel] <= pos_nxt;
        sum_r[item_r.channel] <= sum_nxt;
      end
      if (div_take) begin
        mean_r[item_r.channel] <= div_res.quotient;
      end
      if (eval_en) begin
        rp_r <= rp_nxt;
        rl_r <= rl_nxt;
        iso_r <= iso_nxt;
        seen_r <= seen_nxt;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= q_item;
      addr_r <= rd_addr;
      rd_r <= win_mem[rd_addr];
    end
    if (div_start) begin
      win_mem[addr_r] <= item_r.sample_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (div_take) begin
      res_avg_r <= div_res.quotient;
    end else if (eval_en) begin
      res_avg_r <= mean_r[smah_pkg::CH_LINE];
    end
    if (load_out) begin
      out_data_r.average_mv <= res_avg_r;
      out_data_r.on_reserve <= rp_r;
      out_data_r.reserve_is_low <= rl_r;
      out_data_r.isolation_active <= iso_r;
      out_data_r.valid_mask <= mask;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

`default_nettype wire

[hdl/supply_monitor_average_hysteresis.sv]
// Top level: threshold registers, front queue and back end of the supply monitor.
// Depends on smah_pkg, smah_front, smah_back.
//
//   port group  | dir | handshake          | payload
//   in_         | in  | in_valid/in_stall  | smah_pkg::in_item_t
//   out_        | out | out_valid/out_stall| smah_pkg::out_item_t
//   cfg_        | in  | cfg_we             | cfg_index, cfg_wdata
//
// A sample's mean comes from the shared divider, which produces 4 quotient bits per cycle;
// a tick does not use the divider.
// A two-item queue keeps accepting, until it is full, while the back end works or the result waits.
// rst_n is synchronous, active low; ring entries are not cleared, fill counts are.
// Results hold while stalled; the sender must hold items while stalled, which the block itself does not enforce.
`default_nettype none

module supply_monitor_average_hysteresis #(
  parameter int WINDOW_LENGTH = smah_pkg::WINDOW_LENGTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire smah_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output smah_pkg::out_item_t                      out_data,
  input  wire logic                                cfg_we,
  input  wire logic [smah_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [smah_pkg::MV_W-1:0]           cfg_wdata
);

  smah_pkg::cfg_t    cfg_r;
  smah_pkg::q_item_t q_item;
  logic              q_valid;
  logic              q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_absent_mv <= smah_pkg::RST_LINE_ABSENT;
      cfg_r.line_present_mv <= smah_pkg::RST_LINE_PRESENT;
      cfg_r.reserve_low_mv <= smah_pkg::RST_RESERVE_LOW;
      cfg_r.reserve_ok_mv <= smah_pkg::RST_RESERVE_OK;
      cfg_r.isolation_trip_mv <= smah_pkg::RST_ISO_TRIP;
      cfg_r.isolation_clear_mv <= smah_pkg::RST_ISO_CLEAR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        smah_pkg::CFG_LINE_ABSENT:  cfg_r.line_absent_mv <= cfg_wdata;
        smah_pkg::CFG_LINE_PRESENT: cfg_r.line_present_mv <= cfg_wdata;
        smah_pkg::CFG_RESERVE_LOW:  cfg_r.reserve_low_mv <= cfg_wdata;
        smah_pkg::CFG_RESERVE_OK:   cfg_r.reserve_ok_mv <= cfg_wdata;
        smah_pkg::CFG_ISO_TRIP:     cfg_r.isolation_trip_mv <= cfg_wdata;
        smah_pkg::CFG_ISO_CLEAR:    cfg_r.isolation_clear_mv <= cfg_wdata;
        default: ;
      endcase
    end
  end

  smah_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  smah_back #(
    .WINDOW_LENGTH(WINDOW_LENGTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
